/* rtl/core/positional_list_insert_delete_assert.svh */
// ----------------------------------------------------------------------------
// Positional list assertion macros
// Shared wrappers for the concurrent checks of the positional list block.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication, reset-qualified.
`define PLI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset-qualified.
`define PLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/pli_pkg.sv */
// ----------------------------------------------------------------------------
// Positional list package
// Codes, widths and shared types of the positional list block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 7;
	localparam int ACT_W     = 2;
	localparam int ST_W      = 2;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_NODEL = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

	// Load request from the sequencer to the output register.
	typedef struct packed {
		logic            load;
		logic            from_ram;
		logic            last;
		logic [ST_W-1:0] status;
	} out_ld_t;

endpackage

`default_nettype wire

/* rtl/core/positional_list_insert_delete.sv */
// Positional list: an ordered list of up to DEPTH signed 32-bit values.
// Input channel (in_valid/in_stall) carries action, position and value:
// insert places value at position (appending past the end), delete removes
// the entry at position, read streams out every entry in order.
// Output channel (out_valid/out_stall) carries element, is_last and status.
// Insert and delete give one item with status only; a full list, a delete
// past the end and a read of an empty list give one flagged item.
// One item is worked on at a time; in_stall stays high until its last result
// is loaded into the output register.
// Insert or delete moves k entries through the entry RAM (separate read and
// write ports), one read and one write-back per cycle.
// Read streams out n entries in order; the registered RAM read is hidden by
// holding one entry in the RAM output register while the output register
// waits.
// A stalled receiver holds the output item steady and pauses the read walk.
// Reset clears the length and control state; entry RAM contents are not
// cleared and are never read before being written.
// ----------------------------------------------------------------------------
// Positional list insert/delete top level
// Sequencer, entry RAM and output register of the positional list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_delete #(
	parameter int DEPTH = pli_pkg::DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [pli_pkg::ACT_W-1:0]         action,
	input  wire logic [pli_pkg::POS_W-1:0]         position,
	input  wire logic signed [pli_pkg::DATA_W-1:0] value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [pli_pkg::DATA_W-1:0]      element,
	output logic                                   is_last,
	output logic [pli_pkg::ST_W-1:0]               status
);

	localparam int AW = $clog2(DEPTH);

	// RAM port wiring
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [pli_pkg::DATA_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [pli_pkg::DATA_W-1:0] ram_rdata;

	// Handoff between the sequencer and the output register
	pli_pkg::out_ld_t out_ld;
	logic             out_free;

	// Sequencer: decode the item, shift or stream entries, track length.
	pli_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.position (position),
		.value    (value),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.out_free (out_free),
		.out_ld   (out_ld)
	);

	// Entry store: one write and one registered read per cycle.
	pli_ram #(
		.WIDTH(pli_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Output register: hold each result until the receiver takes it.
	pli_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (out_ld),
		.ram_data (ram_rdata),
		.out_stall(out_stall),
		.out_free (out_free),
		.out_valid(out_valid),
		.element  (element),
		.is_last  (is_last),
		.status   (status)
	);

endmodule

`default_nettype wire

/* rtl/core/pli_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/pli_out.sv */
// ----------------------------------------------------------------------------
// Positional list output register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_out (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire pli_pkg::out_ld_t                ld,
	input  wire logic [pli_pkg::DATA_W-1:0]      ram_data,
	input  wire logic                            out_stall,
	output logic                                 out_free,
	output logic                                 out_valid,
	output logic signed [pli_pkg::DATA_W-1:0]    element,
	output logic                                 is_last,
	output logic [pli_pkg::ST_W-1:0]             status
);

	logic out_v_q;

	assign out_free  = !out_v_q || !out_stall;
	assign out_valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			element <= '0;
			is_last <= 1'b0;
			status  <= pli_pkg::ST_OK;
		end else if (ld.load) begin
			out_v_q <= 1'b1;
			element <= ld.from_ram ? $signed(ram_data) : '0;
			is_last <= ld.last;
			status  <= ld.status;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/pli_ctrl.sv */
// ----------------------------------------------------------------------------
// Positional list sequencer
// Accepts items, walks the entry RAM to shift or read out, tracks length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_insert_delete_assert.svh"

module pli_ctrl #(
	parameter int DEPTH = pli_pkg::DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [pli_pkg::ACT_W-1:0]         action,
	input  wire logic [pli_pkg::POS_W-1:0]         position,
	input  wire logic signed [pli_pkg::DATA_W-1:0] value,
	output logic                                   ram_we,
	output logic [$clog2(DEPTH)-1:0]               ram_waddr,
	output logic [pli_pkg::DATA_W-1:0]             ram_wdata,
	output logic                                   ram_re,
	output logic [$clog2(DEPTH)-1:0]               ram_raddr,
	input  wire logic [pli_pkg::DATA_W-1:0]        ram_rdata,
	input  wire logic                              out_free,
	output pli_pkg::out_ld_t                       out_ld
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SHIFT = 3'd1;
	localparam logic [2:0] S_FIN   = 3'd2;
	localparam logic [2:0] S_DONE  = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;

	logic [2:0]                  state_q;
	logic [LW-1:0]               len_q;
	logic [LW-1:0]               cnt_q;
	logic [AW-1:0]               rd_q;
	logic [LW-1:0]               pos_q;
	logic [pli_pkg::ACT_W-1:0]   act_q;
	logic [pli_pkg::DATA_W-1:0]  val_q;
	logic [pli_pkg::ST_W-1:0]    st_q;
	logic                        wr_v_s1;
	logic [AW-1:0]               wr_addr_s1;
	logic                        pend_q;
	logic                        pend_last_q;

	logic          full;
	logic [LW-1:0] ins_p;
	logic          del_ok;
	logic [LW-1:0] del_p;
	logic          is_ins;
	logic          issue_shift;
	logic          issue_rd;
	logic          move;

	assign full   = (len_q == LW'(DEPTH));
	assign ins_p  = (position > pli_pkg::POS_W'(len_q)) ? len_q : LW'(position);
	assign del_ok = (len_q != '0) && (position < pli_pkg::POS_W'(len_q));
	assign del_p  = LW'(position);
	assign is_ins = (act_q == pli_pkg::ACT_INSERT);

	assign in_stall    = (state_q != S_IDLE);
	assign issue_shift = (state_q == S_SHIFT) && (cnt_q != '0);
	assign move        = (state_q == S_READ) && pend_q && out_free;
	assign issue_rd    = (state_q == S_READ) && (cnt_q != '0) && (!pend_q || move);

	assign ram_re    = issue_shift || issue_rd;
	assign ram_raddr = rd_q;
	assign ram_we    = ((state_q == S_SHIFT) && wr_v_s1) || ((state_q == S_FIN) && is_ins);
	assign ram_waddr = (state_q == S_FIN) ? AW'(pos_q) : wr_addr_s1;
	assign ram_wdata = (state_q == S_FIN) ? val_q : ram_rdata;

	always_comb begin
		out_ld.load     = move || ((state_q == S_DONE) && out_free);
		out_ld.from_ram = move;
		out_ld.last     = move ? pend_last_q : 1'b1;
		out_ld.status   = move ? pli_pkg::ST_OK : st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			cnt_q       <= '0;
			rd_q        <= '0;
			pos_q       <= '0;
			act_q       <= pli_pkg::ACT_INSERT;
			val_q       <= '0;
			st_q        <= pli_pkg::ST_OK;
			wr_v_s1     <= 1'b0;
			wr_addr_s1  <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q <= action;
						case (action)
							pli_pkg::ACT_INSERT: begin
								if (full) begin
									st_q    <= pli_pkg::ST_FULL;
									state_q <= S_DONE;
								end else begin
									pos_q   <= ins_p;
									val_q   <= value;
									cnt_q   <= len_q - ins_p;
									rd_q    <= AW'(len_q - LW'(1));
									state_q <= S_SHIFT;
								end
							end
							pli_pkg::ACT_DELETE: begin
								if (del_ok) begin
									pos_q   <= del_p;
									cnt_q   <= len_q - del_p - LW'(1);
									rd_q    <= AW'(del_p + LW'(1));
									state_q <= S_SHIFT;
								end else begin
									st_q    <= pli_pkg::ST_NODEL;
									state_q <= S_DONE;
								end
							end
							pli_pkg::ACT_READ: begin
								if (len_q == '0) begin
									st_q    <= pli_pkg::ST_EMPTY;
									state_q <= S_DONE;
								end else begin
									rd_q    <= '0;
									cnt_q   <= len_q;
									pend_q  <= 1'b0;
									state_q <= S_READ;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SHIFT: begin
					wr_v_s1 <= issue_shift;
					if (issue_shift) begin
						wr_addr_s1 <= is_ins ? AW'(rd_q + 1'b1) : AW'(rd_q - 1'b1);
						rd_q       <= is_ins ? AW'(rd_q - 1'b1) : AW'(rd_q + 1'b1);
						cnt_q      <= cnt_q - LW'(1);
					end else if (!wr_v_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					len_q   <= is_ins ? LW'(len_q + LW'(1)) : LW'(len_q - LW'(1));
					st_q    <= pli_pkg::ST_OK;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (issue_rd) begin
						rd_q        <= AW'(rd_q + 1'b1);
						cnt_q       <= cnt_q - LW'(1);
						pend_last_q <= (cnt_q == LW'(1));
						pend_q      <= 1'b1;
					end else if (move) begin
						pend_q <= 1'b0;
					end
					if ((cnt_q == '0) && !pend_q) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PLI_ASSERT_NEXT(a_shift_wb, clk, arst_n, issue_shift, ram_we && wr_v_s1, "shift read not written back")
	`PLI_ASSERT_IMPL(a_load_free, clk, arst_n, out_ld.load, out_free, "result loaded over a held item")
	`PLI_ASSERT_IMPL(a_len_max, clk, arst_n, 1'b1, len_q <= LW'(DEPTH), "length past capacity")
	`PLI_ASSERT_NEXT(a_pend_hold, clk, arst_n, (state_q == S_READ) && pend_q && !move, pend_q, "pending entry dropped")
	`PLI_ASSERT_IMPL(a_rw_clash, clk, arst_n, ram_re && ram_we, ram_raddr != ram_waddr, "read and write hit one entry")

endmodule

`default_nettype wire

/* test/positional_list_checker.sv */
// ----------------------------------------------------------------------------
// Positional list checker
// Watches both channels of the positional list, keeps its own copy of the
// list, works out the results of each accepted item and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_checker
	import pli_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic                     in_stall,
	input  wire logic [ACT_W-1:0]         action,
	input  wire logic [POS_W-1:0]         position,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic                     out_valid,
	input  wire logic                     out_stall,
	input  wire logic signed [DATA_W-1:0] element,
	input  wire logic                     is_last,
	input  wire logic [ST_W-1:0]          status,
	output int                            fail_count,
	output int                            pending_results,
	output int                            items_seen,
	output int                            results_seen
);

	typedef struct packed {
		logic signed [DATA_W-1:0] element;
		logic                     is_last;
		logic [ST_W-1:0]          status;
	} list_result_t;

	list_result_t             awaited_results[$];
	logic signed [DATA_W-1:0] list_values[$];

	initial begin
		fail_count      = 0;
		pending_results = 0;
		items_seen      = 0;
		results_seen    = 0;
	end

	task automatic report_mismatch(input string what);
		$display("%0t ns  list check: %s", $time, what);
		fail_count++;
	endtask

	function automatic void queue_result(input logic signed [DATA_W-1:0] elem,
			input logic last, input logic [ST_W-1:0] st);
		list_result_t r;
		r.element = elem;
		r.is_last = last;
		r.status  = st;
		awaited_results.push_back(r);
	endfunction

	// Apply one item to the list copy and queue the results it causes.
	function automatic void apply_list_op(input logic [ACT_W-1:0] act,
			input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] val);
		int slot;
		case (act)
			ACT_INSERT: begin
				if (list_values.size() >= DEPTH) begin
					queue_result('0, 1'b1, ST_FULL);
				end else begin
					slot = (int'(pos) > list_values.size()) ? list_values.size() : int'(pos);
					list_values.insert(slot, val);
					queue_result('0, 1'b1, ST_OK);
				end
			end
			ACT_DELETE: begin
				if (list_values.size() == 0 || int'(pos) >= list_values.size()) begin
					queue_result('0, 1'b1, ST_NODEL);
				end else begin
					list_values.delete(int'(pos));
					queue_result('0, 1'b1, ST_OK);
				end
			end
			ACT_READ: begin
				if (list_values.size() == 0) begin
					queue_result('0, 1'b1, ST_EMPTY);
				end else begin
					for (int k = 0; k < list_values.size(); k++)
						queue_result(list_values[k], k == list_values.size() - 1, ST_OK);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic compare_result();
		list_result_t want;
		if (awaited_results.size() == 0) begin
			report_mismatch($sformatf("result with nothing awaited: element %0d last %0b status %0d",
				$signed(element), is_last, status));
		end else begin
			want = awaited_results.pop_front();
			if (element !== want.element)
				report_mismatch($sformatf("element %0d, want %0d",
					$signed(element), $signed(want.element)));
			if (is_last !== want.is_last)
				report_mismatch($sformatf("is_last %0b, want %0b", is_last, want.is_last));
			if (status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", status, want.status));
		end
		results_seen++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				compare_result();
			if (in_valid && !in_stall) begin
				apply_list_op(action, position, value);
				items_seen++;
			end
			pending_results = awaited_results.size();
		end
	end

endmodule

/* test/tb_positional_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// Positional list testbench
// Drives insert, delete and read items into the positional list under three
// stall profiles; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_positional_list_insert_delete
	import pli_pkg::*;
;

	localparam int               LIST_DEPTH = DEPTH_DEF;
	// Action code the block leaves unused; items carrying it are dropped.
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [ACT_W-1:0]         action;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] element;
	logic                     is_last;
	logic [ST_W-1:0]          status;

	int fail_count;
	int pending_results;
	int items_seen;
	int results_seen;

	// Idle odds in percent for each side; changed between phases.
	int send_idle_pct;
	int recv_idle_pct;

	positional_list_insert_delete #(
		.DEPTH(LIST_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.position (position),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.element  (element),
		.is_last  (is_last),
		.status   (status)
	);

	positional_list_checker #(
		.DEPTH(LIST_DEPTH)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.position       (position),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.element        (element),
		.is_last        (is_last),
		.status         (status),
		.fail_count     (fail_count),
		.pending_results(pending_results),
		.items_seen     (items_seen),
		.results_seen   (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop: far beyond the slowest correct run, where every read streams
	// a full list against a mostly stalled receiver.
	initial begin
		#4_000_000;
		$display("Timeout: %0d results still awaited", pending_results);
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver: stall at random at each falling edge, per the current odds.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Present one item at a falling edge, after a random idle gap, and hold it
	// until the rising edge that accepts it. Leave valid high on return; the
	// next call or the drain decides what it does at the next falling edge.
	task automatic send_item(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		position <= pos;
		value    <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and hold off until every awaited result has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
	endtask

	// Half the time short positions, where the list usually is; otherwise the whole
	// range up to the append-only index.
	function automatic logic [POS_W-1:0] pick_position();
		if ($urandom_range(1) == 0)
			return POS_W'($urandom_range(LIST_DEPTH));
		return POS_W'($urandom_range(7));
	endfunction

	initial begin
		int                pick;
		logic [ACT_W-1:0]  act;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		out_stall     = 1'b0;
		action        = ACT_INSERT;
		position      = '0;
		value         = '0;
		send_idle_pct = 32;
		recv_idle_pct = 57;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty-list corners first.
		send_item(ACT_READ,   '0, 32'sd0);
		send_item(ACT_DELETE, '0, 32'sd0);
		// Build a five-entry list: append past the end, insert at the head,
		// in the middle and exactly at the length; use the value extremes.
		send_item(ACT_INSERT, POS_W'(LIST_DEPTH), 32'sh7fff_ffff);
		send_item(ACT_INSERT, 7'd0, 32'sh8000_0000);
		send_item(ACT_INSERT, 7'd1, 32'sd0);
		send_item(ACT_INSERT, 7'd3, -32'sd1);
		send_item(ACT_INSERT, 7'd2, 32'sh5555_5555);
		send_item(ACT_READ,   '0, 32'sd0);
		// Deletes at the length and far past it change nothing.
		send_item(ACT_DELETE, 7'd5, 32'sd0);
		send_item(ACT_DELETE, POS_W'(LIST_DEPTH), 32'sd0);
		// Remove from middle, head and tail.
		send_item(ACT_DELETE, 7'd2, 32'sd0);
		send_item(ACT_DELETE, 7'd0, 32'sd0);
		send_item(ACT_DELETE, 7'd2, 32'sd0);
		// Unused code: no result, list untouched.
		send_item(ACT_UNUSED, POS_W'(LIST_DEPTH), 32'shaaaa_aaaa);
		send_item(ACT_READ,   '0, 32'sd0);
		send_item(ACT_DELETE, 7'd0, 32'sd0);
		send_item(ACT_DELETE, 7'd0, 32'sd0);
		send_item(ACT_READ,   '0, 32'sd0);
		// Single entry: its one read result is also the last.
		send_item(ACT_INSERT, 7'd0, 32'shaaaa_aaaa);
		send_item(ACT_READ,   '0, 32'sd0);
		send_item(ACT_DELETE, 7'd0, 32'sd0);

		// Phase one: fill from empty to beyond full with random positions and
		// values, reading back now and then; the last inserts hit a full list.
		for (int i = 0; i < LIST_DEPTH + 4; i++) begin
			send_item(ACT_INSERT, pick_position(), $urandom());
			if (i % 17 == 16)
				send_item(ACT_READ, pick_position(), $urandom());
		end
		send_item(ACT_READ, '0, 32'sd0);

		// Pause the sender until the block has caught up completely.
		drain_results();

		// Phase two: swap the idle odds; from the full list, deletes are the commonest item.
		send_idle_pct = 57;
		recv_idle_pct = 32;
		for (int i = 0; i < 35; i++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				act = ACT_DELETE;
			else if (pick < 70)
				act = ACT_INSERT;
			else if (pick < 92)
				act = ACT_READ;
			else
				act = ACT_UNUSED;
			send_item(act, pick_position(), $urandom());
		end

		drain_results();

		// Phase three: no idling on either side, back-to-back items.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 35; i++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				act = ACT_DELETE;
			else if (pick < 75)
				act = ACT_INSERT;
			else if (pick < 95)
				act = ACT_READ;
			else
				act = ACT_UNUSED;
			send_item(act, pick_position(), $urandom());
		end
		send_item(ACT_READ, '0, 32'sd0);

		// Wait out the tail: all results back, then a margin for stray output.
		drain_results();
		repeat (100) @(negedge clk);

		$display("Ran %0d items, %0d results compared: list filled past full (%0d entries),",
			items_seen, results_seen, LIST_DEPTH);
		$display("then worked with mixed items under three stall profiles.");
		if (fail_count == 0 && pending_results == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
